/* rtl/periodic_task_dispatcher_assert.svh */
// Assertion macros shared by the dispatcher RTL.
`ifndef PERIODIC_TASK_DISPATCHER_ASSERT_SVH
`define PERIODIC_TASK_DISPATCHER_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define PTD_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("dispatcher check failed");

// Condition implies consequence in the next cycle.
`define PTD_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("dispatcher check failed");

`endif

/* rtl/ptd_pkg.sv */
// Package: types, widths and codes of the periodic task dispatcher.
package ptd_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int RESULT_CAP    = 16;
    localparam int FIRE_W        = 5;

    localparam int OP_W    = 2;
    localparam int IVL_W   = 31;
    localparam int DUR_W   = 16;
    localparam int TIME_W  = 32;
    localparam int BASE_W  = 16;
    localparam int KIND_W  = 3;
    localparam int TIDX_W  = 4;

    // x / 3 == (x * RECIP3) >> 33 for any 32-bit x
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_SHIFT  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SHIFTED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DUE     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd4;

    typedef struct packed {
        logic [IVL_W-1:0]  ivl;
        logic [DUR_W-1:0]  dur;
        logic [TIME_W-1:0] last;
        logic [TIME_W-1:0] shift;
    } entry_t;

endpackage

/* rtl/ptd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
module ptd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/periodic_task_dispatcher.sv */
// Periodic task dispatcher: task table in RAM, pairwise phase spreading, tick scan.
//
// Requests enter on s_* (valid/ready) and carry an operation: add a task,
// spread the phases, or tick with the current time. Results leave on m_*
// (valid/ready); m_last_result marks the final result of a request.
// shift_base must be written through cfg_* only while the block is idle; the
// user is bound by this, as the block does not enforce it. One request is
// processed at a time; s_ready is high only when idle. Per operation:
//   add   - its single result is registered once the output register is free.
//   tick  - one RAM read and one check/write per table entry; at most 16 tasks
//           fire per tick.
//   shift - every pair i<j costs a RAM read, a set-up step and, unless a value is
//           zero, a 32-step bit-serial remainder unit and a write-back step;
//           there are N*(N-1)/2 pairs, and each outer task adds a read of its own.
// The table RAM (one read and one write port) sets the tick rate; the
// remainder unit sets the shift rate.
// Reset clears the task count and the control state; table contents need no
// clearing since only added entries are ever read.
// A stalled m_ready holds the result register; the scan waits at the next
// result until the register frees, so nothing is lost or repeated.
module periodic_task_dispatcher #(
    parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ptd_pkg::OP_W-1:0]    s_operation,
    input  logic [ptd_pkg::IVL_W-1:0]   s_task_interval,
    input  logic [ptd_pkg::DUR_W-1:0]   s_task_max_duration,
    input  logic [ptd_pkg::TIME_W-1:0]  s_current_time,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ptd_pkg::KIND_W-1:0]  m_kind,
    output logic [ptd_pkg::TIDX_W-1:0]  m_task_index,
    output logic                        m_last_result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ptd_pkg::BASE_W-1:0]  cfg_shift_base
);
    import ptd_pkg::*;
    `include "periodic_task_dispatcher_assert.svh"

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int ENT_W = $bits(entry_t);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);
    localparam logic [FIRE_W-1:0] FIRE_CAP = FIRE_W'(RESULT_CAP);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ADD  = 4'd1;
    localparam logic [3:0] ST_SRDI = 4'd2;
    localparam logic [3:0] ST_SLAT = 4'd3;
    localparam logic [3:0] ST_SRDJ = 4'd4;
    localparam logic [3:0] ST_SMOD = 4'd5;
    localparam logic [3:0] ST_SDIV = 4'd6;
    localparam logic [3:0] ST_SWR  = 4'd7;
    localparam logic [3:0] ST_SEND = 4'd8;
    localparam logic [3:0] ST_TRD  = 4'd9;
    localparam logic [3:0] ST_TCHK = 4'd10;
    localparam logic [3:0] ST_TEND = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [FIRE_W-1:0] fired_reg, fired_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  pidx_reg, pidx_next;
    logic [BASE_W-1:0] base_reg;

    logic [IVL_W-1:0]  ivl_in_reg, ivl_in_next;
    logic [DUR_W-1:0]  dur_in_reg, dur_in_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [OP_W-1:0]   op_reg, op_next;

    logic [TIME_W-1:0]       ai_reg, ai_next;
    logic [DUR_W-1:0]        duri_reg, duri_next;
    logic [IVL_W+TIME_W-1:0] prod_reg, prod_next;

    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] dvd_reg, dvd_next;
    logic [TIME_W-1:0] dvs_reg, dvs_next;
    logic [5:0]        dcnt_reg, dcnt_next;

    logic              mv_reg;
    logic [KIND_W-1:0] mk_reg;
    logic [TIDX_W-1:0] mi_reg;
    logic              ml_reg;

    logic              emit;
    logic [KIND_W-1:0] emit_kind;
    logic [CNT_W-1:0]  emit_idx;
    logic              emit_last;
    logic [CNT_W+TIDX_W-1:0] emit_idx_wide;

    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    entry_t            ram_wdata, ram_rdata;

    logic              out_free;
    logic [TIME_W-1:0] b_val, big, lesser, due, inc;
    logic [TIME_W:0]   trial;

    ptd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_TASKS),
        .ADDR_W(IDX_W)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_free  = !mv_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign b_val  = {1'b0, ram_rdata.ivl} + ram_rdata.shift;
    assign big    = (ai_reg > b_val) ? ai_reg : b_val;
    assign lesser = (ai_reg > b_val) ? b_val : ai_reg;
    assign due    = ram_rdata.last + {1'b0, ram_rdata.ivl} + ram_rdata.shift;
    assign inc    = {2'b00, prod_reg[IVL_W+TIME_W-1:33]} + {16'd0, duri_reg}
                  + {16'd0, base_reg};
    assign trial  = {rem_reg, dvd_reg[TIME_W-1]};
    assign emit_idx_wide = {{TIDX_W{1'b0}}, emit_idx};

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        fired_next  = fired_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        ivl_in_next = ivl_in_reg;
        dur_in_next = dur_in_reg;
        now_next    = now_reg;
        op_next     = op_reg;
        ai_next     = ai_reg;
        duri_next   = duri_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        dcnt_next   = dcnt_reg;
        emit        = 1'b0;
        emit_kind   = KIND_ADDED;
        emit_idx    = '0;
        emit_last   = 1'b1;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = count_reg[IDX_W-1:0];
        ram_raddr   = i_reg[IDX_W-1:0];
        ram_wdata   = ram_rdata;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ivl_in_next = s_task_interval;
                    dur_in_next = s_task_max_duration;
                    now_next    = s_current_time;
                    op_next     = s_operation;
                    i_next      = '0;
                    fired_next  = '0;
                    pend_next   = 1'b0;
                    case (s_operation)
                        OP_ADD:   state_next = ST_ADD;
                        OP_SHIFT: state_next = ST_SRDI;
                        OP_TICK:  state_next = ST_TRD;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (count_reg == CNT_MAX) begin
                        emit_kind = KIND_FULL;
                    end else begin
                        ram_we          = 1'b1;
                        ram_wdata.ivl   = ivl_in_reg;
                        ram_wdata.dur   = dur_in_reg;
                        ram_wdata.last  = '0;
                        ram_wdata.shift = '0;
                        emit_idx        = count_reg;
                        count_next      = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SRDI: begin
                // stop once no partner j remains for i
                if ({1'b0, i_reg} + 1'b1 >= {1'b0, count_reg}) begin
                    state_next = ST_SEND;
                end else begin
                    ram_re     = 1'b1;
                    state_next = ST_SLAT;
                end
            end
            ST_SLAT: begin
                ai_next    = {1'b0, ram_rdata.ivl} + ram_rdata.shift;
                duri_next  = ram_rdata.dur;
                prod_next  = ram_rdata.ivl * RECIP3;
                j_next     = i_reg + 1'b1;
                state_next = ST_SRDJ;
            end
            ST_SRDJ: begin
                if (j_reg >= count_reg) begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_SRDI;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = j_reg[IDX_W-1:0];
                    state_next = ST_SMOD;
                end
            end
            ST_SMOD: begin
                if (lesser == '0) begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SRDJ;
                end else begin
                    rem_next   = '0;
                    dvd_next   = big;
                    dvs_next   = lesser;
                    dcnt_next  = 6'd32;
                    state_next = ST_SDIV;
                end
            end
            ST_SDIV: begin
                // one restoring remainder step per cycle
                if (trial >= {1'b0, dvs_reg}) begin
                    rem_next = TIME_W'(trial - {1'b0, dvs_reg});
                end else begin
                    rem_next = trial[TIME_W-1:0];
                end
                dvd_next  = {dvd_reg[TIME_W-2:0], 1'b0};
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == 6'd1) begin
                    state_next = ST_SWR;
                end
            end
            ST_SWR: begin
                if (rem_reg == '0) begin
                    ram_we          = 1'b1;
                    ram_waddr       = j_reg[IDX_W-1:0];
                    ram_wdata.shift = ram_rdata.shift + inc;
                end
                j_next     = j_reg + 1'b1;
                state_next = ST_SRDJ;
            end
            ST_SEND: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = KIND_SHIFTED;
                    state_next = ST_IDLE;
                end
            end
            ST_TRD: begin
                if (i_reg >= count_reg || fired_reg == FIRE_CAP) begin
                    state_next = ST_TEND;
                end else begin
                    ram_re     = 1'b1;
                    state_next = ST_TCHK;
                end
            end
            ST_TCHK: begin
                if (now_reg > due) begin
                    // hold until the previous firing can be handed out
                    if (!pend_reg || out_free) begin
                        ram_we         = 1'b1;
                        ram_waddr      = i_reg[IDX_W-1:0];
                        ram_wdata.last = now_reg;
                        emit           = pend_reg;
                        emit_kind      = KIND_DUE;
                        emit_idx       = pidx_reg;
                        emit_last      = 1'b0;
                        pend_next      = 1'b1;
                        pidx_next      = i_reg;
                        fired_next     = fired_reg + 1'b1;
                        i_next         = i_reg + 1'b1;
                        state_next     = ST_TRD;
                    end
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_TRD;
                end
            end
            ST_TEND: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = pend_reg ? KIND_DUE : KIND_NONE;
                    emit_idx   = pend_reg ? pidx_reg : '0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            base_reg  <= '0;
            mv_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            fired_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            fired_reg <= fired_next;
            if (cfg_valid) begin
                base_reg <= cfg_shift_base;
            end
            if (emit) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        pidx_reg   <= pidx_next;
        ivl_in_reg <= ivl_in_next;
        dur_in_reg <= dur_in_next;
        now_reg    <= now_next;
        op_reg     <= op_next;
        ai_reg     <= ai_next;
        duri_reg   <= duri_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        dvs_reg    <= dvs_next;
        dcnt_reg   <= dcnt_next;
        if (emit) begin
            mk_reg <= emit_kind;
            mi_reg <= emit_idx_wide[TIDX_W-1:0];
            ml_reg <= emit_last;
        end
    end

    assign m_valid       = mv_reg;
    assign m_kind        = mk_reg;
    assign m_task_index  = mi_reg;
    assign m_last_result = ml_reg;

    `PTD_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_MAX)
    `PTD_ASSERT_NOW(a_emit_free, aclk, aresetn, emit, out_free)
    `PTD_ASSERT_NOW(a_write_state, aclk, aresetn, ram_we,
        state_reg == ST_ADD || state_reg == ST_SWR || state_reg == ST_TCHK)
    `PTD_ASSERT_NEXT(a_accept_op, aclk, aresetn, s_valid && s_ready,
        op_reg == $past(s_operation))

endmodule
